>>> design/key_debounce_long_press_assert.svh
// assertion macros used by the checker
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// a implies b in the same cycle, skipped while in reset
`define KDLP_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("kdlp same-cycle check failed");

// a implies b in the next cycle, skipped while in reset
`define KDLP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("kdlp next-cycle check failed");

// a implies b in the next cycle, always checked
`define KDLP_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("kdlp reset check failed");

`endif

>>> design/kdlp_pkg.sv
`default_nettype none

package kdlp_pkg;

   localparam int NUM_KEYS = 4;
   localparam int KEY_W = 2;
   localparam int TIME_W = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [15:0] DEBOUNCE_DEFAULT = 16'd50;
   localparam logic [15:0] LONG_PRESS_DEFAULT = 16'd1000;
   localparam logic [2:0] ACTIVE_KEYS_DEFAULT = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_TIME    = 2'd0,
      CSR_PRESSED_POLARITY = 2'd1,
      CSR_LONG_PRESS_TIME  = 2'd2,
      CSR_ACTIVE_KEYS      = 2'd3
   } csr_index_type;

   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_SCAN = 1'b1;

   localparam logic [1:0] EVT_PRESS      = 2'd0;
   localparam logic [1:0] EVT_LONG_PRESS = 2'd1;
   localparam logic [1:0] EVT_RELEASE    = 2'd2;

   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key_index;
      logic              raw_level;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_index_res;
      logic [1:0]        key_event;
      logic [TIME_W-1:0] held_ms;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/key_debounce_long_press.sv
`default_nettype none

// channel   ports                      direction
// request   req_valid/req_stall/req_data  in: edge event or scan per key
// response  rsp_valid/rsp_stall/rsp_data  out: press, long press or release
// config    csr_we/csr_index/csr_wdata    in: write only
//
// one item per cycle unless a held result stalls it; a result passes the
// input register, then per-key read-modify-write into the result register
// reset clears key state to released and restores register defaults
// a stalled result only holds back the next item that makes a result

module key_debounce_long_press (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire kdlp_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output kdlp_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [kdlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kdlp_pkg::*;

   logic [15:0] debounce_ff;
   logic        polarity_ff;
   logic [15:0] long_time_ff;
   logic [2:0]  active_ff;

   logic              last_level_ff [NUM_KEYS];
   logic [TIME_W-1:0] change_time_ff [NUM_KEYS];
   logic              stable_ff [NUM_KEYS];
   logic              long_rep_ff [NUM_KEYS];

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              req_take, rsp_free, s1_go, has_res, in_use, pressed;
   logic              last_in, stable_in, long_in;
   logic [TIME_W-1:0] change_in, elapsed;
   logic [KEY_W-1:0]  k;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_DEFAULT;
         polarity_ff  <= 1'b0;
         long_time_ff <= LONG_PRESS_DEFAULT;
         active_ff    <= ACTIVE_KEYS_DEFAULT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TIME:    debounce_ff  <= csr_wdata;
            CSR_PRESSED_POLARITY: polarity_ff  <= csr_wdata[0];
            CSR_LONG_PRESS_TIME:  long_time_ff <= csr_wdata;
            CSR_ACTIVE_KEYS:      active_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign k        = s1_data_ff.key_index;
   assign pressed  = (s1_data_ff.raw_level == polarity_ff);
   assign in_use   = (int'(k) < NUM_KEYS) && ({1'b0, k} < active_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!has_res || rsp_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      last_in   = last_level_ff[k];
      change_in = change_time_ff[k];
      stable_in = stable_ff[k];
      long_in   = long_rep_ff[k];
      has_res   = 1'b0;
      elapsed   = s1_data_ff.now_ms - change_time_ff[k];
      rsp_data_in.key_index_res = k;
      rsp_data_in.key_event     = EVT_RELEASE;
      rsp_data_in.held_ms       = '0;
      if (in_use) begin
         if (s1_data_ff.action == ACT_EDGE) begin
            if (pressed != last_level_ff[k] && elapsed >= {16'd0, debounce_ff}) begin
               last_in   = pressed;
               change_in = s1_data_ff.now_ms;
               stable_in = pressed;
               if (pressed) long_in = 1'b0;
            end
         end else begin
            // a level change restarts the hold timer
            if (last_level_ff[k] != pressed) begin
               change_in = s1_data_ff.now_ms;
               last_in   = pressed;
               elapsed   = '0;
            end
            if (elapsed >= {16'd0, debounce_ff}) begin
               has_res = 1'b1;
               if (pressed != stable_ff[k]) begin
                  stable_in = pressed;
                  if (pressed) long_in = 1'b0;
               end
               if (stable_in && !long_in && elapsed > {16'd0, long_time_ff})
                  long_in = 1'b1;
               if (stable_in) begin
                  rsp_data_in.key_event = long_in ? EVT_LONG_PRESS : EVT_PRESS;
                  rsp_data_in.held_ms   = elapsed;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            last_level_ff[i]  <= 1'b0;
            change_time_ff[i] <= '0;
            stable_ff[i]      <= 1'b0;
            long_rep_ff[i]    <= 1'b0;
         end
      end else if (s1_go) begin
         last_level_ff[k]  <= last_in;
         change_time_ff[k] <= change_in;
         stable_ff[k]      <= stable_in;
         long_rep_ff[k]    <= long_in;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_go) s1_valid_in = 1'b0;
      if (req_take) s1_valid_in = 1'b1;
      rsp_valid_in = rsp_free ? 1'b0 : rsp_valid_ff;
      if (s1_go && has_res) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_data_ff <= req_data;
      if (s1_go && has_res) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> design/kdlp_checker.sv
`default_nettype none
`include "key_debounce_long_press_assert.svh"

module kdlp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire kdlp_pkg::req_type                 req_data,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire kdlp_pkg::rsp_type                 rsp_data,
   input wire logic                              csr_we,
   input wire logic [kdlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input wire logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kdlp_pkg::*;

   logic unused_ok;
   logic rsp_held, evt_known, is_release;
   assign unused_ok = req_valid ^ (^req_data) ^ csr_we ^ (^csr_index) ^ (^csr_wdata);
   assign rsp_held  = rsp_valid && rsp_stall;
   assign evt_known = (rsp_data.key_event == EVT_PRESS) ||
                      (rsp_data.key_event == EVT_LONG_PRESS) ||
                      (rsp_data.key_event == EVT_RELEASE);
   assign is_release = rsp_valid && (rsp_data.key_event == EVT_RELEASE);

   // a held result keeps its contents
   `KDLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   // only the three event codes leave the block
   `KDLP_ASSERT_SAME(a_evt_code, clock, reset, rsp_valid, evt_known)
   // release never carries a hold time
   `KDLP_ASSERT_SAME(a_rel_zero, clock, reset, is_release, rsp_data.held_ms == '0)
   // reset empties both stages
   `KDLP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (.*);

`default_nettype wire
